FILE: src/cfcg_pkg.sv
// package for the can frame crc / counter / gear checker
// holds the shared types, codes and crc byte step; used by every module in src

package cfcg_pkg;

   localparam int FAIL_COUNT_WIDTH = 16;
   localparam int CRC_STAGES       = 7;
   localparam int QUEUE_DEPTH      = 4;
   localparam int QUEUE_PTR_WIDTH  = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_WIDTH  = $clog2(QUEUE_DEPTH + 1);
   localparam int CSR_ADDR_WIDTH   = 4;

   // register indexes (paddr[3:2])
   localparam logic [1:0] REG_MATCH_ID   = 2'd0;
   localparam logic [1:0] REG_CRC_POLY   = 2'd1;
   localparam logic [1:0] REG_CRC_XOROUT = 2'd2;

   localparam logic [10:0] MATCH_ID_RESET   = 11'd1017;
   localparam logic [7:0]  CRC_POLY_RESET   = 8'h1D;
   localparam logic [7:0]  CRC_XOROUT_RESET = 8'h04;

   localparam logic [2:0] STATUS_IGNORED  = 3'd0;
   localparam logic [2:0] STATUS_CRC_FAIL = 3'd1;
   localparam logic [2:0] STATUS_BAD_NIB  = 3'd2;
   localparam logic [2:0] STATUS_ACCEPTED = 3'd3;
   localparam logic [2:0] STATUS_SEQ_GAP  = 3'd4;

   localparam logic [1:0] GEAR_PARK    = 2'd0;
   localparam logic [1:0] GEAR_REVERSE = 2'd1;
   localparam logic [1:0] GEAR_NEUTRAL = 2'd2;
   localparam logic [1:0] GEAR_DRIVE   = 2'd3;

   localparam logic [7:0] GEAR_BYTE_PARK    = 8'h33;
   localparam logic [7:0] GEAR_BYTE_NEUTRAL = 8'h31;
   localparam logic [7:0] GEAR_BYTE_REVERSE = 8'h32;
   localparam logic [7:0] GEAR_BYTE_DRIVE   = 8'h35;

   localparam logic [3:0] SEQ_MARK = 4'hF;

   typedef enum logic [1:0] {
      KIND_IGNORED   = 2'd0,
      KIND_CRC_FAIL  = 2'd1,
      KIND_BAD_NIB   = 2'd2,
      KIND_OK        = 2'd3
   } kind_type;

   typedef struct packed {
      kind_type   kind;
      logic [3:0] seq;
      logic [7:0] gear_byte;
      logic [7:0] lever;
   } item_type;

   // one byte of msb-first crc-8, init folded in by caller
   function automatic logic [7:0] crc8_byte(input logic [7:0] rem,
                                            input logic [7:0] data,
                                            input logic [7:0] poly);
      logic [7:0] r;
      r = rem ^ data;
      for (int b = 0; b < 8; b++) begin
         if (r[7]) begin
            r = {r[6:0], 1'b0} ^ poly;
         end else begin
            r = {r[6:0], 1'b0};
         end
      end
      return r;
   endfunction

endpackage

FILE: src/cfcg_front.sv
// front end: accepts frames, runs the crc over bytes 1..7 one byte per stage
// and classifies each frame; uses cfcg_pkg

module cfcg_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [10:0]          req_can_id,
   input  logic [63:0]          req_frame_data,
   input  logic [10:0]          match_id,
   input  logic [7:0]           crc_poly,
   input  logic [7:0]           crc_xorout,
   output logic                 out_valid,
   input  logic                 out_ready,
   output cfcg_pkg::item_type   out_item
);

   localparam int LAST = cfcg_pkg::CRC_STAGES - 1;

   logic [cfcg_pkg::CRC_STAGES-1:0] valid_ff, valid_in;
   logic [cfcg_pkg::CRC_STAGES-1:0] match_ff, match_in;
   logic [7:0]  rem_ff  [cfcg_pkg::CRC_STAGES];
   logic [7:0]  rem_in  [cfcg_pkg::CRC_STAGES];
   logic [63:0] data_ff [cfcg_pkg::CRC_STAGES];
   logic [63:0] data_in [cfcg_pkg::CRC_STAGES];
   logic        advance;
   logic [7:0]  crc_final;
   logic [63:0] last_data;

   // whole pipe moves together; stalls only when the queue is full
   assign advance    = !valid_ff[LAST] || out_ready;
   assign req_tready = advance;

   always_comb begin
      valid_in[0] = req_tvalid;
      match_in[0] = (req_can_id == match_id);
      data_in[0]  = req_frame_data;
      rem_in[0]   = cfcg_pkg::crc8_byte(8'h00, req_frame_data[15:8], crc_poly);
      for (int s = 1; s < cfcg_pkg::CRC_STAGES; s++) begin
         valid_in[s] = valid_ff[s-1];
         match_in[s] = match_ff[s-1];
         data_in[s]  = data_ff[s-1];
         // stage s folds in byte s+1
         rem_in[s]   = cfcg_pkg::crc8_byte(rem_ff[s-1], data_ff[s-1][8*(s+1) +: 8],
                                           crc_poly);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (advance) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         match_ff <= match_in;
         for (int s = 0; s < cfcg_pkg::CRC_STAGES; s++) begin
            rem_ff[s]  <= rem_in[s];
            data_ff[s] <= data_in[s];
         end
      end
   end

   assign last_data = data_ff[LAST];
   assign crc_final = rem_ff[LAST] ^ crc_xorout;

   always_comb begin
      out_item.seq       = last_data[11:8];
      out_item.gear_byte = last_data[55:48];
      out_item.lever     = last_data[39:32];
      if (!match_ff[LAST]) begin
         out_item.kind = cfcg_pkg::KIND_IGNORED;
      end else if (crc_final != last_data[7:0]) begin
         out_item.kind = cfcg_pkg::KIND_CRC_FAIL;
      end else if (last_data[15:12] != cfcg_pkg::SEQ_MARK) begin
         out_item.kind = cfcg_pkg::KIND_BAD_NIB;
      end else begin
         out_item.kind = cfcg_pkg::KIND_OK;
      end
   end

   assign out_valid = valid_ff[LAST];

endmodule

FILE: src/cfcg_queue.sv
// short queue of classified frames between the front and back ends
// uses cfcg_pkg for the item type and depth

module cfcg_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push_valid,
   output logic                 push_ready,
   input  cfcg_pkg::item_type   push_item,
   output logic                 pop_valid,
   input  logic                 pop_ready,
   output cfcg_pkg::item_type   pop_item
);

   localparam logic [cfcg_pkg::QUEUE_PTR_WIDTH-1:0] PTR_LAST =
      cfcg_pkg::QUEUE_PTR_WIDTH'(cfcg_pkg::QUEUE_DEPTH - 1);
   localparam logic [cfcg_pkg::QUEUE_CNT_WIDTH-1:0] CNT_FULL =
      cfcg_pkg::QUEUE_CNT_WIDTH'(cfcg_pkg::QUEUE_DEPTH);

   cfcg_pkg::item_type entry_ff [cfcg_pkg::QUEUE_DEPTH];
   logic [cfcg_pkg::QUEUE_PTR_WIDTH-1:0] wr_ptr_ff, wr_ptr_in;
   logic [cfcg_pkg::QUEUE_PTR_WIDTH-1:0] rd_ptr_ff, rd_ptr_in;
   logic [cfcg_pkg::QUEUE_CNT_WIDTH-1:0] count_ff, count_in;
   logic push, pop;

   assign push_ready = (count_ff != CNT_FULL);
   assign pop_valid  = (count_ff != '0);
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;
   assign pop_item   = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_FULL)
      else $error("queue count beyond depth");

   a_pop_moves_rd: assert property (@(posedge clock) disable iff (reset)
      pop && !push |=> count_ff != CNT_FULL)
      else $error("queue full right after a pop without push");

endmodule

FILE: src/cfcg_back.sv
// back end: applies a classified frame to the held gear, sequence and fault
// counters and holds the result for the rsp channel; uses cfcg_pkg

module cfcg_back (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 item_valid,
   output logic                 item_ready,
   input  cfcg_pkg::item_type   item,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [2:0]           rsp_status,
   output logic [1:0]           rsp_gear,
   output logic [7:0]           rsp_gear_byte,
   output logic [7:0]           rsp_lever_position,
   output logic [15:0]          rsp_crc_fail_count,
   output logic [15:0]          rsp_sequence_fail_count
);

   localparam logic [cfcg_pkg::FAIL_COUNT_WIDTH-1:0] CNT_MAX = '1;

   logic        take;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [2:0]  status_ff, status_in;
   logic [1:0]  gear_ff, gear_in;
   logic [7:0]  gear_byte_ff, gear_byte_in;
   logic [7:0]  lever_ff, lever_in;
   logic [3:0]  last_seq_ff, last_seq_in;
   logic        seq_seen_ff, seq_seen_in;
   logic [cfcg_pkg::FAIL_COUNT_WIDTH-1:0] crc_cnt_ff, crc_cnt_in;
   logic [cfcg_pkg::FAIL_COUNT_WIDTH-1:0] seq_cnt_ff, seq_cnt_in;
   logic [3:0]  step;
   logic [31:0] crc_wide, seq_wide;

   // held state only moves when a new result loads, so it stays put while stalled
   assign item_ready = !rsp_valid_ff || rsp_tready;
   assign take       = item_valid && item_ready;
   assign step       = item.seq - last_seq_ff;

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      status_in    = status_ff;
      gear_in      = gear_ff;
      gear_byte_in = gear_byte_ff;
      lever_in     = lever_ff;
      last_seq_in  = last_seq_ff;
      seq_seen_in  = seq_seen_ff;
      crc_cnt_in   = crc_cnt_ff;
      seq_cnt_in   = seq_cnt_ff;
      if (take) begin
         rsp_valid_in = 1'b1;
         case (item.kind)
            cfcg_pkg::KIND_IGNORED: begin
               status_in = cfcg_pkg::STATUS_IGNORED;
            end
            cfcg_pkg::KIND_CRC_FAIL: begin
               status_in  = cfcg_pkg::STATUS_CRC_FAIL;
               crc_cnt_in = (crc_cnt_ff == CNT_MAX) ? crc_cnt_ff : crc_cnt_ff + 1'b1;
            end
            cfcg_pkg::KIND_BAD_NIB: begin
               status_in  = cfcg_pkg::STATUS_BAD_NIB;
               seq_cnt_in = (seq_cnt_ff == CNT_MAX) ? seq_cnt_ff : seq_cnt_ff + 1'b1;
            end
            cfcg_pkg::KIND_OK: begin
               status_in = cfcg_pkg::STATUS_ACCEPTED;
               // first counter after reset has nothing to step from
               if (seq_seen_ff && step != 4'd1 && step != 4'd2) begin
                  status_in  = cfcg_pkg::STATUS_SEQ_GAP;
                  seq_cnt_in = (seq_cnt_ff == CNT_MAX) ? seq_cnt_ff : seq_cnt_ff + 1'b1;
               end
               last_seq_in  = item.seq;
               seq_seen_in  = 1'b1;
               gear_byte_in = item.gear_byte;
               lever_in     = item.lever;
               case (item.gear_byte)
                  cfcg_pkg::GEAR_BYTE_PARK:    gear_in = cfcg_pkg::GEAR_PARK;
                  cfcg_pkg::GEAR_BYTE_REVERSE: gear_in = cfcg_pkg::GEAR_REVERSE;
                  cfcg_pkg::GEAR_BYTE_NEUTRAL: gear_in = cfcg_pkg::GEAR_NEUTRAL;
                  cfcg_pkg::GEAR_BYTE_DRIVE:   gear_in = cfcg_pkg::GEAR_DRIVE;
                  default:                     gear_in = gear_ff;
               endcase
            end
            default: begin
               status_in = cfcg_pkg::STATUS_IGNORED;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         gear_ff      <= cfcg_pkg::GEAR_PARK;
         gear_byte_ff <= '0;
         lever_ff     <= '0;
         last_seq_ff  <= '0;
         seq_seen_ff  <= 1'b0;
         crc_cnt_ff   <= '0;
         seq_cnt_ff   <= '0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         gear_ff      <= gear_in;
         gear_byte_ff <= gear_byte_in;
         lever_ff     <= lever_in;
         last_seq_ff  <= last_seq_in;
         seq_seen_ff  <= seq_seen_in;
         crc_cnt_ff   <= crc_cnt_in;
         seq_cnt_ff   <= seq_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      status_ff <= status_in;
   end

   assign crc_wide = 32'(crc_cnt_ff);
   assign seq_wide = 32'(seq_cnt_ff);

   assign rsp_tvalid              = rsp_valid_ff;
   assign rsp_status              = status_ff;
   assign rsp_gear                = gear_ff;
   assign rsp_gear_byte           = gear_byte_ff;
   assign rsp_lever_position      = lever_ff;
   assign rsp_crc_fail_count      = crc_wide[15:0];
   assign rsp_sequence_fail_count = seq_wide[15:0];

   a_crc_cnt_only_on_fail: assert property (@(posedge clock) disable iff (reset)
      !(take && item.kind == cfcg_pkg::KIND_CRC_FAIL) |=> $stable(crc_cnt_ff))
      else $error("crc fail count moved without a crc failure");

   a_first_seq_clean: assert property (@(posedge clock) disable iff (reset)
      take && item.kind == cfcg_pkg::KIND_OK && !seq_seen_ff
      |=> rsp_valid_ff && status_ff == cfcg_pkg::STATUS_ACCEPTED)
      else $error("first counter after reset flagged as gap");

   a_ignored_holds: assert property (@(posedge clock) disable iff (reset)
      take && item.kind == cfcg_pkg::KIND_IGNORED
      |=> $stable(gear_ff) && $stable(seq_cnt_ff) && $stable(last_seq_ff))
      else $error("ignored frame changed held state");

endmodule

FILE: src/can_frame_crc_counter_gear_check.sv
// top level of the can frame crc / counter / gear checker
// holds the csr registers and ties cfcg_front, cfcg_queue and cfcg_back; uses cfcg_pkg
//
// req channel: one received frame per transfer, can_id and eight payload bytes.
// rsp channel: exactly one result per frame, in frame order: status, held gear,
// held gear byte, held lever byte and both saturating fault counts.
// csr port: apb-style, match_id at 0x0, crc_poly at 0x4, crc_xorout at 0x8;
// write only while no frame is in flight.
// path: a frame transfer loads the first of 7 crc stages; the frame then takes
// six more stage hops, the queue write and the result register before its
// result shows on rsp; one frame per cycle sustained while rsp_tready is high.
// the front pipe stalls only when the 4-entry queue is full, and the queue
// fills only while rsp_tready is held low, so req_tready drops once the queue
// has filled behind a stalled receiver, while the result register holds its value.
// reset: pipe and queue empty, gear park, held bytes and counters zero, no
// rolling counter seen yet, registers back to 1017 / 0x1D / 0x04.

module can_frame_crc_counter_gear_check (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [79:0]                         req_tdata,  // can_id, frame_data
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // status, gear, gear_byte, lever_position, crc_fail_count, sequence_fail_count
   output logic [55:0]                         rsp_tdata,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [cfcg_pkg::CSR_ADDR_WIDTH-1:0] csr_paddr,
   input  logic [31:0]                         csr_pwdata,
   output logic [31:0]                         csr_prdata,
   output logic                                csr_pready
);

   logic [10:0] match_id_ff;
   logic [7:0]  crc_poly_ff;
   logic [7:0]  crc_xorout_ff;
   logic        csr_write;

   logic               fr_valid, fr_ready;
   cfcg_pkg::item_type fr_item;
   logic               q_valid, q_ready;
   cfcg_pkg::item_type q_item;

   logic [2:0]  rsp_status;
   logic [1:0]  rsp_gear;
   logic [7:0]  rsp_gear_byte;
   logic [7:0]  rsp_lever_position;
   logic [15:0] rsp_crc_fail_count;
   logic [15:0] rsp_sequence_fail_count;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         match_id_ff   <= cfcg_pkg::MATCH_ID_RESET;
         crc_poly_ff   <= cfcg_pkg::CRC_POLY_RESET;
         crc_xorout_ff <= cfcg_pkg::CRC_XOROUT_RESET;
      end else if (csr_write) begin
         case (csr_paddr[3:2])
            cfcg_pkg::REG_MATCH_ID:   match_id_ff   <= csr_pwdata[10:0];
            cfcg_pkg::REG_CRC_POLY:   crc_poly_ff   <= csr_pwdata[7:0];
            cfcg_pkg::REG_CRC_XOROUT: crc_xorout_ff <= csr_pwdata[7:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[3:2])
         cfcg_pkg::REG_MATCH_ID:   csr_prdata = 32'(match_id_ff);
         cfcg_pkg::REG_CRC_POLY:   csr_prdata = 32'(crc_poly_ff);
         cfcg_pkg::REG_CRC_XOROUT: csr_prdata = 32'(crc_xorout_ff);
         default:                  csr_prdata = '0;
      endcase
   end

   cfcg_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_can_id     (req_tdata[10:0]),
      .req_frame_data (req_tdata[74:11]),
      .match_id       (match_id_ff),
      .crc_poly       (crc_poly_ff),
      .crc_xorout     (crc_xorout_ff),
      .out_valid      (fr_valid),
      .out_ready      (fr_ready),
      .out_item       (fr_item)
   );

   cfcg_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (fr_valid),
      .push_ready (fr_ready),
      .push_item  (fr_item),
      .pop_valid  (q_valid),
      .pop_ready  (q_ready),
      .pop_item   (q_item)
   );

   cfcg_back u_back (
      .clock                   (clock),
      .reset                   (reset),
      .item_valid              (q_valid),
      .item_ready              (q_ready),
      .item                    (q_item),
      .rsp_tvalid              (rsp_tvalid),
      .rsp_tready              (rsp_tready),
      .rsp_status              (rsp_status),
      .rsp_gear                (rsp_gear),
      .rsp_gear_byte           (rsp_gear_byte),
      .rsp_lever_position      (rsp_lever_position),
      .rsp_crc_fail_count      (rsp_crc_fail_count),
      .rsp_sequence_fail_count (rsp_sequence_fail_count)
   );

   assign rsp_tdata = {3'b000, rsp_sequence_fail_count, rsp_crc_fail_count,
                       rsp_lever_position, rsp_gear_byte, rsp_gear, rsp_status};

endmodule
